// ----- rtl/sde_pkg.sv -----
// Shared types, constants and helpers for the signed radix digit emitter.
// No dependencies; imported by every module in this folder.
package sde_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int MAX_BASE    = 16;
    localparam int MAX_DIGITS  = 32;

    localparam int BASE_W    = 5;
    localparam int CHAR_W    = 8;
    localparam int DIGIT_W   = 4;
    localparam int ALPHA_W   = 2 * 64;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;

    localparam int NIBBLES = (VALUE_WIDTH + DIGIT_W - 1) / DIGIT_W;
    localparam int PAD_W   = NIBBLES * DIGIT_W;
    localparam int NIB_W   = $clog2(NIBBLES);
    localparam int CNT_W   = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W   = $clog2(MAX_BASE);

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_SIZE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_HIGH = 2'd2;

    localparam logic [BASE_W-1:0] BASE_SIZE_RST     = 5'd10;
    localparam logic [63:0]       ALPHABET_LOW_RST  = 64'h3736_3534_3332_3130;
    localparam logic [63:0]       ALPHABET_HIGH_RST = 64'h6665_6463_6261_3938;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    typedef struct packed {
        logic done;
        logic bad;
    } chk_sts_t;

    typedef struct packed {
        logic               digit_valid;
        logic [DIGIT_W-1:0] digit;
        logic               finished;
    } div_sts_t;

    function automatic logic [CHAR_W-1:0] glyph(input logic [ALPHA_W-1:0] alpha,
                                                 input logic [DIGIT_W-1:0] d);
        return alpha[d * CHAR_W +: CHAR_W];
    endfunction

endpackage

// ----- rtl/sde_base_check.sv -----
// Serial validity check of the configured radix and digit alphabet.
// Depends on sde_pkg; one alphabet entry is compared against the rest per cycle.
module sde_base_check import sde_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [BASE_W-1:0]  base_size,
    input  logic [ALPHA_W-1:0] alphabet,
    output chk_sts_t           sts
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             bad_reg, bad_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    logic [CHAR_W-1:0] cur_char;
    logic              bad_now;
    logic              range_bad;
    logic              at_last;

    assign range_bad = (base_size < BASE_W'(2)) || (base_size > BASE_W'(MAX_BASE));
    assign at_last   = ({1'b0, idx_reg} == (base_size - BASE_W'(1)));
    assign cur_char  = glyph(alphabet, DIGIT_W'(idx_reg));

    always_comb begin
        bad_now = (cur_char == CHAR_NUL) || (cur_char == CHAR_PLUS) ||
                  (cur_char == CHAR_MINUS);
        for (int j = 0; j < MAX_BASE; j++) begin
            if ((BASE_W'(j) > {1'b0, idx_reg}) && (BASE_W'(j) < base_size) &&
                (glyph(alphabet, DIGIT_W'(j)) == cur_char)) begin
                bad_now = 1'b1;
            end
        end
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = done_reg;
        bad_next  = bad_reg;
        idx_next  = idx_reg;
        if (start) begin
            idx_next  = '0;
            bad_next  = range_bad;
            done_next = range_bad;
            busy_next = !range_bad;
        end else if (busy_reg) begin
            if (bad_now) begin
                bad_next  = 1'b1;
                done_next = 1'b1;
                busy_next = 1'b0;
            end else if (at_last) begin
                done_next = 1'b1;
                busy_next = 1'b0;
            end else begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            bad_reg  <= 1'b0;
            idx_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            bad_reg  <= bad_next;
            idx_reg  <= idx_next;
        end
    end

    assign sts.done = done_reg;
    assign sts.bad  = bad_reg;

endmodule

// ----- rtl/sde_divider.sv -----
// Digit-serial division of the magnitude by the radix, one hex digit of the dividend per cycle.
// Depends on sde_pkg; delivers remainders least significant first.
module sde_divider import sde_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] magnitude,
    input  logic [BASE_W-1:0]      radix,
    output div_sts_t               sts
);

    logic               busy_reg, busy_next;
    logic [PAD_W-1:0]   quo_reg, quo_next;
    logic [DIGIT_W-1:0] rem_reg, rem_next;
    logic [NIB_W-1:0]   nib_reg, nib_next;
    logic               nz_reg, nz_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               dvalid_reg, dvalid_next;
    logic [DIGIT_W-1:0] digit_reg, digit_next;
    logic               fin_reg, fin_next;
    logic [BASE_W-1:0]  radix_reg, radix_next;

    logic [DIGIT_W-1:0] in_nib;
    logic [DIGIT_W-1:0] q_nib;
    logic [DIGIT_W-1:0] r_step;
    logic [BASE_W-1:0]  part;

    assign in_nib = quo_reg[PAD_W-1 -: DIGIT_W];

    always_comb begin
        r_step = rem_reg;
        q_nib  = '0;
        part   = '0;
        for (int k = DIGIT_W - 1; k >= 0; k--) begin
            part = {r_step, in_nib[k]};
            if (part >= radix_reg) begin
                part     = part - radix_reg;
                q_nib[k] = 1'b1;
            end
            r_step = part[DIGIT_W-1:0];
        end
    end

    always_comb begin
        busy_next   = busy_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        nib_next    = nib_reg;
        nz_next     = nz_reg;
        cnt_next    = cnt_reg;
        dvalid_next = 1'b0;
        digit_next  = digit_reg;
        fin_next    = fin_reg;
        radix_next  = radix_reg;
        if (start) begin
            busy_next  = 1'b1;
            quo_next   = PAD_W'(magnitude);
            rem_next   = '0;
            nib_next   = '0;
            nz_next    = 1'b0;
            cnt_next   = '0;
            fin_next   = 1'b0;
            radix_next = radix;
        end else if (busy_reg) begin
            quo_next = {quo_reg[PAD_W-DIGIT_W-1:0], q_nib};
            if (nib_reg == NIB_W'(NIBBLES - 1)) begin
                dvalid_next = 1'b1;
                digit_next  = r_step;
                cnt_next    = cnt_reg + CNT_W'(1);
                rem_next    = '0;
                nib_next    = '0;
                nz_next     = 1'b0;
                if ((!nz_reg && (q_nib == '0)) || (cnt_reg == CNT_W'(MAX_DIGITS - 1))) begin
                    busy_next = 1'b0;
                    fin_next  = 1'b1;
                end
            end else begin
                rem_next = r_step;
                nib_next = nib_reg + NIB_W'(1);
                nz_next  = nz_reg || (q_nib != '0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            nib_reg    <= '0;
            cnt_reg    <= '0;
            dvalid_reg <= 1'b0;
            fin_reg    <= 1'b0;
        end else begin
            busy_reg   <= busy_next;
            nib_reg    <= nib_next;
            cnt_reg    <= cnt_next;
            dvalid_reg <= dvalid_next;
            fin_reg    <= fin_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        nz_reg    <= nz_next;
        digit_reg <= digit_next;
        radix_reg <= radix_next;
    end

    assign sts.digit_valid = dvalid_reg;
    assign sts.digit       = digit_reg;
    assign sts.finished    = fin_reg;

    a_digit_below_radix: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && (radix_reg >= BASE_W'(2)) && (radix_reg <= BASE_W'(MAX_BASE)))
            |=> (!sts.digit_valid || ({1'b0, sts.digit} < radix_reg)))
        else $error("divider produced a digit not below the radix");

endmodule

// ----- rtl/signed_radix_digit_emitter.sv -----
// Top level: writes one signed value as text in a configured base, one character per transaction.
// Depends on sde_pkg, sde_base_check and sde_divider.
//
//  channel  | ports                                   | transfers
//  ---------+-----------------------------------------+------------------------------------
//  input    | s_valid s_ready s_value                 | one signed value
//  result   | m_valid m_ready m_character m_last      | one character, or one error result
//           | m_bad_base                              |
//  config   | cfg_we cfg_index cfg_wdata              | base_size, alphabet_low/high
//
// Work: the radix check and the serial divider run side by side; the divider handles one hex digit
// of the magnitude per cycle, and the characters follow once both are through.
// Base 10 worst case: 11 characters. An invalid base ends the work early.
// Reset: synchronous on aresetn low; no clearing pass, the digit stack is written before read.
// Stalls: m_ready low holds the output register; the next value is taken once the final
// character of the current one has been loaded into that register.
module signed_radix_digit_emitter import sde_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [VALUE_WIDTH-1:0] s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [CHAR_W-1:0]             m_character,
    output logic                          m_last,
    output logic                          m_bad_base,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_W-1:0]              cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WORK = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    localparam int DEPTH_W = $clog2(MAX_DIGITS + 1);

    state_t state_reg, state_next;

    logic [BASE_W-1:0] base_size_reg;
    logic [63:0]       alpha_low_reg;
    logic [63:0]       alpha_high_reg;

    logic               neg_reg, neg_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [DIGIT_W-1:0] stack_reg [MAX_DIGITS];

    logic              m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0] m_char_reg, m_char_next;
    logic              m_last_reg, m_last_next;
    logic              m_bad_reg, m_bad_next;

    logic                   accept;
    logic                   out_adv;
    logic                   push;
    logic                   pop;
    logic [ALPHA_W-1:0]     alphabet;
    logic [VALUE_WIDTH-1:0] magnitude;
    chk_sts_t               chk_sts;
    div_sts_t               div_sts;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_adv   = !m_valid_reg || m_ready;
    assign alphabet  = {alpha_high_reg, alpha_low_reg};
    assign magnitude = s_value[VALUE_WIDTH-1] ? (~s_value + VALUE_WIDTH'(1)) : s_value;
    assign push      = (state_reg == ST_WORK) && div_sts.digit_valid;

    sde_base_check u_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (accept),
        .base_size (base_size_reg),
        .alphabet  (alphabet),
        .sts       (chk_sts)
    );

    sde_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (accept),
        .magnitude (magnitude),
        .radix     (base_size_reg),
        .sts       (div_sts)
    );

    always_comb begin
        state_next   = state_reg;
        neg_next     = neg_reg;
        depth_next   = depth_reg;
        pop          = 1'b0;
        m_valid_next = m_valid_reg;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        m_bad_next   = m_bad_reg;
        if (out_adv) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    neg_next   = s_value[VALUE_WIDTH-1];
                    depth_next = '0;
                    state_next = ST_WORK;
                end
            end
            ST_WORK: begin
                if (push) begin
                    depth_next = depth_reg + DEPTH_W'(1);
                end
                if (chk_sts.done && (chk_sts.bad || div_sts.finished)) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_adv) begin
                    m_valid_next = 1'b1;
                    if (chk_sts.bad) begin
                        m_char_next = CHAR_NUL;
                        m_last_next = 1'b1;
                        m_bad_next  = 1'b1;
                        state_next  = ST_IDLE;
                    end else if (neg_reg) begin
                        m_char_next = CHAR_MINUS;
                        m_last_next = 1'b0;
                        m_bad_next  = 1'b0;
                        neg_next    = 1'b0;
                    end else begin
                        m_char_next = glyph(alphabet, stack_reg[0]);
                        m_last_next = (depth_reg == DEPTH_W'(1));
                        m_bad_next  = 1'b0;
                        pop         = 1'b1;
                        depth_next  = depth_reg - DEPTH_W'(1);
                        if (depth_reg == DEPTH_W'(1)) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            base_size_reg  <= BASE_SIZE_RST;
            alpha_low_reg  <= ALPHABET_LOW_RST;
            alpha_high_reg <= ALPHABET_HIGH_RST;
            neg_reg        <= 1'b0;
            depth_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            neg_reg     <= neg_next;
            depth_reg   <= depth_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_BASE_SIZE:     base_size_reg  <= cfg_wdata[BASE_W-1:0];
                    CFG_ALPHABET_LOW:  alpha_low_reg  <= cfg_wdata;
                    CFG_ALPHABET_HIGH: alpha_high_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
        m_bad_reg  <= m_bad_next;
        if (push) begin
            stack_reg[0] <= div_sts.digit;
            for (int i = 1; i < MAX_DIGITS; i++) begin
                stack_reg[i] <= stack_reg[i-1];
            end
        end else if (pop) begin
            for (int i = 0; i < MAX_DIGITS - 1; i++) begin
                stack_reg[i] <= stack_reg[i+1];
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_character = m_char_reg;
    assign m_last      = m_last_reg;
    assign m_bad_base  = m_bad_reg;

    a_emit_has_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_EMIT) && !chk_sts.bad) |-> (depth_reg != '0))
        else $error("emitting with an empty digit stack");

    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DEPTH_W'(MAX_DIGITS))
        else $error("digit stack overflow");

    a_error_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_bad_base) |-> (m_last && (m_character == CHAR_NUL)))
        else $error("error transaction not flagged last with a zero character");

    a_idle_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_EMIT) && out_adv && m_last_next) |=> (state_reg == ST_IDLE))
        else $error("final character loaded without returning to idle");

endmodule

// ----- tb/sde_text_check.sv -----
// Checker for the signed radix digit emitter: follows register writes, predicts the characters
// of every accepted value and compares them with each result transaction.
// Depends on sde_pkg; instantiated beside the block by signed_radix_digit_emitter_tb.
module sde_text_check import sde_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic signed [VALUE_WIDTH-1:0] s_value,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [CHAR_W-1:0]             m_character,
    input  logic                          m_last,
    input  logic                          m_bad_base,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_W-1:0]              cfg_wdata,
    output int                            mismatch_count,
    output int                            chars_pending
);

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
        logic              bad_base;
    } text_char_t;

    logic [BASE_W-1:0]  radix;
    logic [ALPHA_W-1:0] alphabet;
    text_char_t         expected_text[$];

    function automatic logic [CHAR_W-1:0] symbol_for(input logic [DIGIT_W-1:0] d);
        return CHAR_W'(alphabet >> (CHAR_W * d));
    endfunction

    function automatic bit radix_valid();
        logic [CHAR_W-1:0] c;
        if (radix < 2 || radix > MAX_BASE) return 1'b0;
        for (int i = 0; i < radix; i++) begin
            c = symbol_for(DIGIT_W'(i));
            if (c == CHAR_NUL || c == CHAR_PLUS || c == CHAR_MINUS) return 1'b0;
            for (int j = i + 1; j < radix; j++) begin
                if (symbol_for(DIGIT_W'(j)) == c) return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic void predict_text(input logic signed [VALUE_WIDTH-1:0] value);
        logic [VALUE_WIDTH-1:0] magnitude;
        logic [DIGIT_W-1:0]     digits [MAX_DIGITS];
        int                     n;
        if (!radix_valid()) begin
            expected_text.push_back(text_char_t'{CHAR_NUL, 1'b1, 1'b1});
            return;
        end
        // two's complement magnitude, so the most negative value wraps to its unsigned form
        magnitude = value;
        if (value[VALUE_WIDTH-1]) magnitude = ~magnitude + 1'b1;
        n = 0;
        do begin
            digits[n] = DIGIT_W'(magnitude % radix);
            n++;
            magnitude = magnitude / radix;
        end while (magnitude != 0 && n < MAX_DIGITS);
        if (value[VALUE_WIDTH-1]) expected_text.push_back(text_char_t'{CHAR_MINUS, 1'b0, 1'b0});
        for (int i = n - 1; i >= 0; i--) begin
            expected_text.push_back(text_char_t'{symbol_for(digits[i]), logic'(i == 0), 1'b0});
        end
    endfunction

    task automatic report_mismatch(input text_char_t want, input text_char_t seen,
                                   input bit orphan);
        if (mismatch_count < 10) begin
            if (orphan) begin
                $display("unexpected transaction: char %h last %b bad_base %b",
                         seen.character, seen.last, seen.bad_base);
            end else begin
                $display("mismatch: expected char %h last %b bad_base %b, got char %h last %b bad_base %b",
                         want.character, want.last, want.bad_base,
                         seen.character, seen.last, seen.bad_base);
            end
        end
        mismatch_count++;
    endtask

    always @(posedge aclk) begin : track
        text_char_t seen;
        text_char_t want;
        if (!aresetn) begin
            radix    = BASE_SIZE_RST;
            alphabet = {ALPHABET_HIGH_RST, ALPHABET_LOW_RST};
            expected_text.delete();
        end else begin
            if (m_valid && m_ready) begin
                seen = text_char_t'{m_character, m_last, m_bad_base};
                if (expected_text.size() == 0) begin
                    report_mismatch('0, seen, 1'b1);
                end else begin
                    want = expected_text.pop_front();
                    if (seen.character !== want.character || seen.last !== want.last ||
                        seen.bad_base !== want.bad_base) begin
                        report_mismatch(want, seen, 1'b0);
                    end
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_BASE_SIZE:     radix = cfg_wdata[BASE_W-1:0];
                    CFG_ALPHABET_LOW:  alphabet[63:0] = cfg_wdata;
                    CFG_ALPHABET_HIGH: alphabet[127:64] = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) predict_text(s_value);
        end
        chars_pending = expected_text.size();
    end

endmodule

// ----- tb/signed_radix_digit_emitter_tb.sv -----
// Top of the signed radix digit emitter testbench: clock, reset, register writes, value and
// result-side stimulus with random idling, and the verdict.
// Depends on sde_pkg, signed_radix_digit_emitter and sde_text_check.
module signed_radix_digit_emitter_tb;
    import sde_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 340;
    localparam int IDLE_PERCENT = 38;
    localparam int HOLD_CYCLES  = 400;

    localparam logic [CFG_IDX_W-1:0]          CFG_UNUSED     = 2'd3;
    localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN      = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX      = ~VALUE_MIN;
    localparam logic [ALPHA_W-1:0]            RESET_ALPHABET = {ALPHABET_HIGH_RST,
                                                                ALPHABET_LOW_RST};

    logic                          aclk        = 1'b0;
    logic                          aresetn     = 1'b0;
    logic                          s_valid     = 1'b0;
    logic                          s_ready;
    logic signed [VALUE_WIDTH-1:0] s_value     = '0;
    logic                          m_valid;
    logic                          m_ready     = 1'b0;
    logic [CHAR_W-1:0]             m_character;
    logic                          m_last;
    logic                          m_bad_base;
    logic                          cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]          cfg_index   = '0;
    logic [CFG_W-1:0]              cfg_wdata   = '0;

    int mismatch_count;
    int chars_pending;
    bit steady          = 1'b0;
    bit hold_off_wanted = 1'b0;

    signed_radix_digit_emitter i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last      (m_last),
        .m_bad_base  (m_bad_base),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

    sde_text_check i_text_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_character    (m_character),
        .m_last         (m_last),
        .m_bad_base     (m_bad_base),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .chars_pending  (chars_pending)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // result side: random back-pressure, with one long hold-off on request
    initial begin : receiver
        forever begin
            @(negedge aclk);
            if (hold_off_wanted) begin
                hold_off_wanted = 1'b0;
                m_ready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) @(negedge aclk);
            end else if (steady) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    task automatic offer_value(input logic signed [VALUE_WIDTH-1:0] v);
        if (!steady) begin
            while ($urandom_range(0, 99) < IDLE_PERCENT) begin
                s_valid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_value <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        wait (chars_pending == 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic program_base(input int radix, input logic [ALPHA_W-1:0] alpha);
        logic [CFG_W-1:0] data;
        settle();
        data = {$urandom, $urandom};
        data[BASE_W-1:0] = BASE_W'(radix);
        write_reg(CFG_BASE_SIZE, data);
        write_reg(CFG_ALPHABET_LOW, alpha[63:0]);
        write_reg(CFG_ALPHABET_HIGH, alpha[127:64]);
    endtask

    function automatic logic [ALPHA_W-1:0] random_alphabet();
        logic [ALPHA_W-1:0] alpha;
        bit   [255:0]       taken;
        logic [CHAR_W-1:0]  c;
        taken = '0;
        taken[CHAR_NUL]   = 1'b1;
        taken[CHAR_PLUS]  = 1'b1;
        taken[CHAR_MINUS] = 1'b1;
        for (int i = 0; i < MAX_BASE; i++) begin
            do c = CHAR_W'($urandom_range(0, 255)); while (taken[c]);
            taken[c] = 1'b1;
            alpha[i*CHAR_W +: CHAR_W] = c;
        end
        return alpha;
    endfunction

    function automatic logic [ALPHA_W-1:0] spoil_alphabet(input logic [ALPHA_W-1:0] alpha,
                                                         input int radix);
        int i;
        int j;
        i = $urandom_range(0, radix - 1);
        case ($urandom_range(0, 3))
            0: alpha[i*CHAR_W +: CHAR_W] = CHAR_NUL;
            1: alpha[i*CHAR_W +: CHAR_W] = CHAR_PLUS;
            2: alpha[i*CHAR_W +: CHAR_W] = CHAR_MINUS;
            default: begin
                j = $urandom_range(0, radix - 2);
                if (j >= i) j++;
                alpha[i*CHAR_W +: CHAR_W] = alpha[j*CHAR_W +: CHAR_W];
            end
        endcase
        return alpha;
    endfunction

    task automatic random_setting();
        int                 radix;
        logic [ALPHA_W-1:0] alpha;
        alpha = random_alphabet();
        case ($urandom_range(0, 9))
            0: radix = 2;
            1: radix = MAX_BASE;
            2: radix = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(17, 31);
            3: begin
                radix = $urandom_range(2, MAX_BASE);
                alpha = spoil_alphabet(alpha, radix);
            end
            default: radix = $urandom_range(2, MAX_BASE);
        endcase
        program_base(radix, alpha);
        if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, {$urandom, $urandom});
    endtask

    function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
        int s;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6: begin
                s = $urandom_range(0, 4095);
                return $urandom_range(0, 1) ? -s : s;
            end
            7: return $urandom_range(0, 1) ? VALUE_MIN : VALUE_MAX;
            8: return VALUE_MIN + $urandom_range(0, 16);
            default: return $urandom_range(0, 40) - 20;
        endcase
    endfunction

    initial begin : stimulus
        logic [ALPHA_W-1:0] alpha;
        int                 sent;
        int                 batch;
        int                 phase;

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // reset setting: decimal
        offer_value(0);
        offer_value(1);
        offer_value(-1);
        offer_value(9);
        offer_value(-10);
        offer_value(VALUE_MAX);
        offer_value(VALUE_MIN);

        program_base(MAX_BASE, RESET_ALPHABET);
        offer_value(VALUE_MAX);
        offer_value(VALUE_MIN);
        offer_value(32'hdeadbeef);
        offer_value(255);

        program_base(2, RESET_ALPHABET);
        offer_value(VALUE_MIN);
        offer_value(VALUE_MAX);
        offer_value(0);

        // radix out of range
        program_base(0, RESET_ALPHABET);
        offer_value(5);
        program_base(1, RESET_ALPHABET);
        offer_value(-5);
        program_base(17, RESET_ALPHABET);
        offer_value(7);
        program_base(31, RESET_ALPHABET);
        offer_value(VALUE_MIN);

        // forbidden and repeated characters
        alpha = RESET_ALPHABET;
        alpha[3*CHAR_W +: CHAR_W] = CHAR_PLUS;
        program_base(10, alpha);
        offer_value(42);
        alpha = RESET_ALPHABET;
        alpha[0 +: CHAR_W] = CHAR_MINUS;
        program_base(10, alpha);
        offer_value(-42);
        alpha = RESET_ALPHABET;
        alpha[15*CHAR_W +: CHAR_W] = CHAR_NUL;
        program_base(MAX_BASE, alpha);
        offer_value(100);
        alpha = RESET_ALPHABET;
        alpha[15*CHAR_W +: CHAR_W] = alpha[0 +: CHAR_W];
        program_base(MAX_BASE, alpha);
        offer_value(-100);

        // characters past the radix are ignored
        program_base(8, {{8{CHAR_MINUS}}, ALPHABET_LOW_RST});
        offer_value(-8);

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            random_setting();
            steady = (phase == 3);
            if (phase == 5) hold_off_wanted = 1'b1;
            batch = $urandom_range(10, 30);
            repeat (batch) offer_value(pick_value());
            sent += batch;
            phase++;
        end
        settle();
        repeat (100) @(posedge aclk);

        if (mismatch_count == 0 && chars_pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- signed_radix_digit_emitter.f -----
rtl/sde_pkg.sv
rtl/sde_base_check.sv
rtl/sde_divider.sv
rtl/signed_radix_digit_emitter.sv
tb/sde_text_check.sv
tb/signed_radix_digit_emitter_tb.sv
